// ----- design/assert_macros.svh -----
// Assertion macros used by the prefetcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Implication with a delayed consequent, disabled while in reset.
`define ASSERT_AFTER2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
		else $error("assertion failed: two-cycle implication");

`endif

// ----- design/dcp_pkg.sv -----
// Shared types and constants of the delta correlation prefetcher.
`timescale 1ns / 1ps
`default_nettype none

package dcp_pkg;

	localparam int HIST_LEN = 4;
	localparam int WAYS     = 4;
	localparam int ADDR_W   = 32;
	localparam int AGE_W    = 16;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [AGE_W-1:0]             age_t;
	typedef logic [WAY_W-1:0]             way_t;
	typedef addr_t [HIST_LEN-1:0]         hist_t;

	// One request as it leaves the input stage.
	typedef struct packed {
		logic  valid;     // request in stage 1
		logic  train;     // primed request: tables and history update
		addr_t address;
		addr_t delta;
		hist_t old_hist;  // history before this request
		hist_t new_hist;  // history with this delta shifted in
	} step_t;

	// Outcome of the table search.
	typedef struct packed {
		logic  hit;
		addr_t pred_delta;
	} search_t;

endpackage

`default_nettype wire

// ----- design/dcp_front.sv -----
// Input stage, delta computation and delta history of the prefetcher.
`timescale 1ns / 1ps
`default_nettype none

module dcp_front import dcp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire addr_t address,
	output step_t      step
);

	logic  valid_s1;
	logic  primed_s1;
	addr_t address_s1;
	addr_t delta_s1;
	logic  primed_q;
	addr_t prev_q;
	hist_t hist_q;
	addr_t prev_eff;
	logic  primed_eff;
	hist_t hist_shift;

	// The request in stage 1 is the true predecessor of an incoming one.
	always_comb begin
		prev_eff   = valid_s1 ? address_s1 : prev_q;
		primed_eff = valid_s1 | primed_q;
		for (int p = 0; p < HIST_LEN - 1; p++) begin
			hist_shift[p] = hist_q[p+1];
		end
		hist_shift[HIST_LEN-1] = delta_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			primed_q <= 1'b0;
			prev_q   <= '0;
			hist_q   <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				primed_q <= 1'b1;
				prev_q   <= address_s1;
				if (primed_s1) begin
					hist_q <= hist_shift;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			address_s1 <= address;
			delta_s1   <= address - prev_eff;
			primed_s1  <= primed_eff;
		end
	end

	assign step.valid    = valid_s1;
	assign step.train    = valid_s1 & primed_s1;
	assign step.address  = address_s1;
	assign step.delta    = delta_s1;
	assign step.old_hist = hist_q;
	assign step.new_hist = hist_shift;

endmodule

`default_nettype wire

// ----- design/dcp_tables.sv -----
// Correlation tables: victim choice, training, parallel search and ageing.
`timescale 1ns / 1ps
`default_nettype none

module dcp_tables import dcp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire step_t step,
	output search_t    search
);

	hist_t key_q  [HIST_LEN][WAYS];
	addr_t pred_q [HIST_LEN][WAYS];
	age_t  age_q  [HIST_LEN][WAYS];

	hist_t key_n  [HIST_LEN][WAYS];
	addr_t pred_n [HIST_LEN][WAYS];
	age_t  age_n  [HIST_LEN][WAYS];
	age_t  age_d  [HIST_LEN][WAYS];
	way_t  victim [HIST_LEN];
	hist_t mkey   [HIST_LEN];
	logic  [HIST_LEN-1:0] hit_t;
	way_t  hit_w  [HIST_LEN];
	logic  any_hit;
	addr_t pred_sel;
	logic  same;

	always_comb begin
		// training: oldest way of each table, ties to the lowest way
		for (int t = 0; t < HIST_LEN; t++) begin
			victim[t] = '0;
			for (int w = 1; w < WAYS; w++) begin
				if (age_q[t][w] > age_q[t][victim[t]]) begin
					victim[t] = WAY_W'(w);
				end
			end
			for (int p = 0; p < HIST_LEN; p++) begin
				mkey[t][p] = (p >= HIST_LEN - 1 - t) ? step.old_hist[p] : '0;
			end
			for (int w = 0; w < WAYS; w++) begin
				if (step.train && (victim[t] == WAY_W'(w))) begin
					key_n[t][w]  = mkey[t];
					pred_n[t][w] = step.delta;
					age_n[t][w]  = '0;
				end else begin
					key_n[t][w]  = key_q[t][w];
					pred_n[t][w] = pred_q[t][w];
					age_n[t][w]  = age_q[t][w];
				end
			end
		end

		// search the trained tables: lowest matching way wins
		for (int t = 0; t < HIST_LEN; t++) begin
			hit_t[t] = 1'b0;
			hit_w[t] = '0;
			for (int w = WAYS - 1; w >= 0; w--) begin
				same = 1'b1;
				for (int p = HIST_LEN - 1 - t; p < HIST_LEN; p++) begin
					if (key_n[t][w][p] != step.new_hist[p]) begin
						same = 1'b0;
					end
				end
				if (same) begin
					hit_t[t] = 1'b1;
					hit_w[t] = WAY_W'(w);
				end
			end
		end

		any_hit  = step.train & (|hit_t);
		// longest match last, so it overrides
		pred_sel = '0;
		for (int t = 0; t < HIST_LEN; t++) begin
			if (hit_t[t]) begin
				pred_sel = pred_n[t][hit_w[t]];
			end
		end

		for (int t = 0; t < HIST_LEN; t++) begin
			for (int w = 0; w < WAYS; w++) begin
				if (!any_hit) begin
					age_d[t][w] = age_n[t][w];
				end else if (hit_t[t] && (hit_w[t] == WAY_W'(w))) begin
					age_d[t][w] = '0;
				end else if (age_n[t][w] != '1) begin
					age_d[t][w] = age_n[t][w] + 1'b1;
				end else begin
					age_d[t][w] = age_n[t][w];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < HIST_LEN; t++) begin
				for (int w = 0; w < WAYS; w++) begin
					key_q[t][w]  <= '0;
					pred_q[t][w] <= '0;
					age_q[t][w]  <= '0;
				end
			end
		end else if (step.train) begin
			key_q  <= key_n;
			pred_q <= pred_n;
			age_q  <= age_d;
		end
	end

	assign search.hit        = any_hit;
	assign search.pred_delta = pred_sel;

endmodule

`default_nettype wire

// ----- design/delta_correlation_prefetcher.sv -----
// Top level of the multi-order delta correlation prefetcher.
`timescale 1ns / 1ps
`default_nettype none

// Delta correlation prefetcher. Raise start with an access address; the
// request is taken at any clock edge where start is high, since busy is
// never asserted: a new request may come every cycle. Exactly one result
// per request appears after the input register and the result register,
// marked by a single-cycle done strobe, and must be captured then as it
// cannot be held back. The first request after reset only primes the
// block and reports no prediction. Later requests train four tables
// (match lengths one to four, four ways each) with the new delta and
// search them longest match first; prefetch_valid marks a hit and
// prefetch_address is the address plus the predicted delta, zero
// otherwise. Throughput is one request per cycle, as each request's table
// update is registered in time for the next request's search.

`include "assert_macros.svh"

module delta_correlation_prefetcher import dcp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire addr_t address,
	output logic       done,
	output logic       prefetch_valid,
	output addr_t      prefetch_address
);

	step_t   step;
	search_t search;
	logic    accept;
	logic    done_q;
	logic    prefetch_valid_q;
	addr_t   prefetch_address_q;

	// busy is tied low: the table update never holds a request back, so requests are never refused
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	dcp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.address (address),
		.step    (step)
	);

	dcp_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.search (search)
	);

	// result register; fields forced low when there is no prediction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q           <= 1'b0;
			prefetch_valid_q <= 1'b0;
		end else begin
			done_q           <= step.valid;
			prefetch_valid_q <= search.hit;
		end
	end

	always_ff @(posedge clk) begin
		prefetch_address_q <= search.hit ? (step.address + search.pred_delta) : '0;
	end

	assign done             = done_q;
	assign prefetch_valid   = prefetch_valid_q;
	assign prefetch_address = prefetch_address_q;

	// every request yields its result after the input and result registers
	`ASSERT_AFTER2(a_done_latency, clk, arst_n, accept, done)
	// a hit needs a primed request in stage 1
	`ASSERT_IMPLY(a_hit_needs_train, clk, arst_n, search.hit, step.train && step.valid)
	// no prediction means a zero address
	`ASSERT_IMPLY(a_miss_zero, clk, arst_n, done && !prefetch_valid, prefetch_address == '0)

endmodule

`default_nettype wire
